// ===== hdl/nearest_palette_color_lookup_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nearest palette color lookup.
// Shared property wrappers with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_LOOKUP_MACROS_SVH
`define NEAREST_PALETTE_COLOR_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPCL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NPCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/npcl_pkg.sv =====
// ----------------------------------------------------------------------------
// npcl_pkg
// Types and constants shared by the nearest palette color lookup.
// ----------------------------------------------------------------------------
package npcl_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;

  localparam int COLOR_W = 8;
  localparam int WORD_W  = 32;
  localparam int DIST_W  = 18;
  localparam int INDEX_W = 8;
  localparam int ENTRY_W = 3 * COLOR_W + WORD_W;

  localparam logic [DIST_W-1:0] DIST_SAT    = '1;
  localparam logic [DIST_W-1:0] LIMIT_RESET = 18'd128;

  // Item selector codes.
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_DISTANCE_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } npcl_state_t;

endpackage

// ===== hdl/npcl_ram.sv =====
// ----------------------------------------------------------------------------
// npcl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module npcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/nearest_palette_color_lookup.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_lookup
// Palette store with a nearest-color search by squared RGB distance.
// ----------------------------------------------------------------------------
// Usage: words arrive on the in_ stream. in_tuser selects the function: clear
// the palette, append an entry (color plus a 32-bit word) or query a pixel.
// Clear and append complete in the cycle the word is accepted and give no
// result. A query scans the stored entries in order, one entry per cycle
// through the palette RAM's read port, and returns one result word on the
// out_ stream with the closest entry's index, word and distance; out_tuser
// flags whether that distance is below the distance_limit register.
// Only one word is processed at a time; in_tready is high while the block is
// idle, also while a finished result still waits in the output register.
// A stalled receiver holds the result in place; a second query then finishes
// its scan and waits until the output register frees up.
// Reset empties the palette (the RAM contents are left alone) and sets the
// distance limit to 128. The limit is written over the APB port at address 0
// and should only change while the block is idle.
// ----------------------------------------------------------------------------
`include "nearest_palette_color_lookup_macros.svh"

module nearest_palette_color_lookup
  import npcl_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // red[7:0], green[15:8], blue[23:16], entry_word[55:24]
  input  logic [1:0]  in_tuser,   // func[1:0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // best_index[7:0], best_word[39:8],
                                  // best_distance[57:40], zeros[63:58]
  output logic [0:0]  out_tuser,  // found[0]
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam int IW = (AW < INDEX_W) ? AW : INDEX_W;

  function automatic logic [2*COLOR_W-1:0] sq_diff(logic [COLOR_W-1:0] a,
                                                   logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return (2*COLOR_W)'(d) * (2*COLOR_W)'(d);
  endfunction

  // Configuration register.
  logic [DIST_W-1:0] limit_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_DISTANCE_LIMIT) ? 32'(limit_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_DISTANCE_LIMIT) begin
      limit_r <= cfg_pwdata[DIST_W-1:0];
    end
  end

  // Control state.
  npcl_state_t state_r, state_nxt;
  logic        in_fire;
  logic [1:0]  func;
  logic        done;
  logic [CW-1:0] entry_count_r;
  logic [AW-1:0] scan_idx_r;
  logic          scan_last;
  logic          rd_vld_r;
  logic          s1_vld_r;
  logic          out_tvalid_r;

  assign func      = in_tuser;
  assign in_fire   = in_tvalid && in_tready;
  assign scan_last = (CW'(scan_idx_r) == entry_count_r - CW'(1));
  // The scan is complete once both pipeline stages are empty; the result is
  // then loaded as soon as the output register is free.
  assign done = (state_r == ST_DRAIN) && !rd_vld_r && !s1_vld_r &&
                (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire && func == FUNC_QUERY) begin
          state_nxt = (entry_count_r == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Palette RAM: {word, blue, green, red} per entry.
  logic               wr_en;
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_en;

  assign wr_en = in_fire && func == FUNC_APPEND && entry_count_r < CW'(PALETTE_DEPTH);
  assign rd_en = (state_r == ST_SCAN);

  npcl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count_r[AW-1:0]),
    .wr_data (in_tdata[ENTRY_W-1:0]),
    .rd_en   (rd_en),
    .rd_addr (scan_idx_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (in_fire && func == FUNC_CLEAR) begin
      entry_count_r <= '0;
    end else if (wr_en) begin
      entry_count_r <= entry_count_r + CW'(1);
    end
  end

  // Scan address and pipeline valid flags.
  logic [AW-1:0] rd_idx_r;
  logic [AW-1:0] s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
      s1_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      s1_vld_r <= rd_vld_r;
      if (in_fire) begin
        scan_idx_r <= '0;
      end else if (rd_en) begin
        scan_idx_r <= scan_idx_r + AW'(1);
      end
    end
  end

  // Queried pixel and distance stage.
  logic [COLOR_W-1:0] pix_red_r, pix_green_r, pix_blue_r;
  logic [DIST_W-1:0]  s1_dist_r;
  logic [WORD_W-1:0]  s1_word_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_red_r   <= in_tdata[7:0];
      pix_green_r <= in_tdata[15:8];
      pix_blue_r  <= in_tdata[23:16];
    end
    rd_idx_r <= scan_idx_r;
    if (rd_vld_r) begin
      s1_dist_r <= DIST_W'(sq_diff(rd_data[7:0], pix_red_r)) +
                   DIST_W'(sq_diff(rd_data[15:8], pix_green_r)) +
                   DIST_W'(sq_diff(rd_data[23:16], pix_blue_r));
      s1_word_r <= rd_data[ENTRY_W-1:3*COLOR_W];
      s1_idx_r  <= rd_idx_r;
    end
  end

  // Running best. Strict compare keeps the lowest index on a tie.
  logic              best_any_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [WORD_W-1:0] best_word_r;
  logic [AW-1:0]     best_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_any_r <= 1'b0;
    end else if (in_fire) begin
      best_any_r <= 1'b0;
    end else if (s1_vld_r) begin
      best_any_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      best_dist_r <= DIST_SAT;
      best_word_r <= '0;
      best_idx_r  <= '0;
    end else if (s1_vld_r && (!best_any_r || s1_dist_r < best_dist_r)) begin
      best_dist_r <= s1_dist_r;
      best_word_r <= s1_word_r;
      best_idx_r  <= s1_idx_r;
    end
  end

  // Output register.
  logic [63:0] out_tdata_r;
  logic        out_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (done) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_found_r <= best_any_r && (best_dist_r < limit_r);
      out_tdata_r <= {6'd0, best_dist_r, best_word_r, INDEX_W'(best_idx_r[IW-1:0])};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_found_r;

  // Checks.
  `NPCL_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, entry_count_r <= CW'(PALETTE_DEPTH))
  `NPCL_ASSERT_IMPL(a_scan_in_range, clk, rst_n, state_r == ST_SCAN,
                    CW'(scan_idx_r) < entry_count_r)
  `NPCL_ASSERT_NEXT(a_query_busy, clk, rst_n, in_fire && func == FUNC_QUERY,
                    state_r != ST_IDLE)
  `NPCL_ASSERT_IMPL(a_pipe_busy, clk, rst_n, rd_vld_r || s1_vld_r, state_r == ST_DRAIN ||
                    state_r == ST_SCAN)
  `NPCL_ASSERT_IMPL(a_result_from_drain, clk, rst_n, $rose(out_tvalid_r),
                    $past(state_r) == ST_DRAIN)

endmodule
